[hdl/rswps_pkg.sv]
// Package for the ring store weighted position sampler.
// Field widths, length clamp, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package rswps_pkg;

	localparam int CAPACITY   = 256;
	localparam int MAX_LENGTH = 512;

	localparam int LEN_W   = 10;
	localparam int DRAW_W  = 17;
	localparam int SLOT_W  = 8;
	localparam int OFF_W   = 9;
	localparam int TOTAL_W = 18;
	localparam int COUNT_W = 9;

	localparam int LenMaxInt = (MAX_LENGTH > (2 ** LEN_W) - 1) ? (2 ** LEN_W) - 1 : MAX_LENGTH;
	localparam logic [LEN_W-1:0] LEN_CLAMP = LEN_W'(LenMaxInt);

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_REPLACE,
		ST_WALK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic add_new;
		logic add_replace;
		logic set_err;
		logic walk_start;
		logic walk_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_add;
		logic full;
		logic bad_draw;
		logic found;
	} status_t;

endpackage

`default_nettype wire

[hdl/rswps_if.sv]
// Request and response channel interfaces for the position sampler.
// Depends on rswps_pkg for field widths.
`default_nettype none

interface rswps_req_if;
	logic                             valid;
	logic                             ready;
	logic                             op;
	logic [rswps_pkg::LEN_W-1:0]      episode_length;
	logic [rswps_pkg::DRAW_W-1:0]     draw;
	logic                             batch_last;

	modport source (output valid, op, episode_length, draw, batch_last, input ready);
	modport sink   (input valid, op, episode_length, draw, batch_last, output ready);
endinterface

interface rswps_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [rswps_pkg::SLOT_W-1:0]     slot_index;
	logic [rswps_pkg::OFF_W-1:0]      offset;
	logic [rswps_pkg::TOTAL_W-1:0]    total_positions;
	logic [rswps_pkg::COUNT_W-1:0]    stored_count;
	logic                             error;
	logic                             batch_end;

	modport source (output valid, slot_index, offset, total_positions, stored_count, error,
		batch_end, input ready);
	modport sink   (input valid, slot_index, offset, total_positions, stored_count, error,
		batch_end, output ready);
endinterface

`default_nettype wire

[hdl/ring_store_weighted_position_sampler.sv]
// Top level of the ring store weighted position sampler.
// Depends on rswps_pkg, rswps_if, rswps_ctrl, rswps_dp (and rswps_ram below it).
//
//   channel  dir  word
//   req      in   op, episode_length, draw, batch_last
//   rsp      out  slot_index, offset, total_positions, stored_count, error, batch_end
//
// One item at a time. An add writes its length in the decode state; once the ring
// is full it first reads the overwritten length, then writes in the replace state. A
// sample walks from slot 0 and ends at the hit slot: the walk reads one stored
// length per cycle from the single read port of the length store.
// Reset clears counters, total, walk flag and controller state only; the store needs no clearing pass.
// A new word is accepted while a result waits in the output register.
`default_nettype none

module ring_store_weighted_position_sampler #(
	parameter int CAPACITY = rswps_pkg::CAPACITY
) (
	input wire logic    clk,
	input wire logic    arst_n,
	rswps_req_if.sink   req,
	rswps_rsp_if.source rsp
);

	rswps_pkg::cmd_t    cmd;
	rswps_pkg::status_t sts;

	rswps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	rswps_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.in_op             (req.op),
		.in_episode_length (req.episode_length),
		.in_draw           (req.draw),
		.in_batch_last     (req.batch_last),
		.slot_index        (rsp.slot_index),
		.offset            (rsp.offset),
		.total_positions   (rsp.total_positions),
		.stored_count      (rsp.stored_count),
		.error             (rsp.error),
		.batch_end         (rsp.batch_end)
	);

endmodule

`default_nettype wire

[hdl/rswps_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rswps_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 256
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[hdl/rswps_ctrl.sv]
// Controller state machine for the position sampler.
// Depends on rswps_pkg for state_t, cmd_t and status_t.
`default_nettype none

module rswps_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              rsp_ready,
	input  wire rswps_pkg::status_t sts,
	output      logic              req_ready,
	output      logic              rsp_valid,
	output      rswps_pkg::cmd_t   cmd
);

	rswps_pkg::state_t state_q, state_nxt;
	logic              out_valid_q;
	logic              out_free;

	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rswps_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_nxt = rswps_pkg::ST_DECODE;
				end
			end
			rswps_pkg::ST_DECODE: begin
				if (sts.is_add) begin
					state_nxt = sts.full ? rswps_pkg::ST_REPLACE : rswps_pkg::ST_FIN;
				end else begin
					state_nxt = sts.bad_draw ? rswps_pkg::ST_FIN : rswps_pkg::ST_WALK;
				end
			end
			rswps_pkg::ST_REPLACE: begin
				state_nxt = rswps_pkg::ST_FIN;
			end
			rswps_pkg::ST_WALK: begin
				if (sts.found) begin
					state_nxt = rswps_pkg::ST_FIN;
				end
			end
			rswps_pkg::ST_FIN: begin
				if (out_free) begin
					state_nxt = rswps_pkg::ST_IDLE;
				end
			end
			default: state_nxt = rswps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			rswps_pkg::ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			rswps_pkg::ST_DECODE: begin
				cmd.add_new    = sts.is_add && !sts.full;
				cmd.set_err    = !sts.is_add && sts.bad_draw;
				cmd.walk_start = !sts.is_add && !sts.bad_draw;
			end
			rswps_pkg::ST_REPLACE: begin
				cmd.add_replace = 1'b1;
			end
			rswps_pkg::ST_WALK: begin
				cmd.walk_step = 1'b1;
			end
			rswps_pkg::ST_FIN: begin
				cmd.load_out = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rswps_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

`default_nettype wire

[hdl/rswps_dp.sv]
// Datapath of the position sampler: length store, counters, running total,
// cumulative walk and the output word register. Depends on rswps_pkg and rswps_ram.
`default_nettype none

module rswps_dp #(
	parameter int CAPACITY = rswps_pkg::CAPACITY
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rswps_pkg::cmd_t                   cmd,
	output      rswps_pkg::status_t                sts,
	input  wire logic                              in_op,
	input  wire logic [rswps_pkg::LEN_W-1:0]       in_episode_length,
	input  wire logic [rswps_pkg::DRAW_W-1:0]      in_draw,
	input  wire logic                              in_batch_last,
	output      logic [rswps_pkg::SLOT_W-1:0]      slot_index,
	output      logic [rswps_pkg::OFF_W-1:0]       offset,
	output      logic [rswps_pkg::TOTAL_W-1:0]     total_positions,
	output      logic [rswps_pkg::COUNT_W-1:0]     stored_count,
	output      logic                              error,
	output      logic                              batch_end
);

	localparam int SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CntW  = $clog2(CAPACITY + 1);
	localparam int TotW  = $clog2(CAPACITY * rswps_pkg::LenMaxInt + 1);
	localparam int CmpW  = (TotW > rswps_pkg::DRAW_W) ? TotW : rswps_pkg::DRAW_W;
	localparam logic [SlotW-1:0] LastSlot = SlotW'(CAPACITY - 1);
	localparam logic [CntW-1:0]  FullCnt  = CntW'(CAPACITY);

	logic                            op_q;
	logic [rswps_pkg::LEN_W-1:0]     len_q;
	logic [rswps_pkg::DRAW_W-1:0]    draw_q;
	logic                            last_q;

	logic [CntW-1:0]                 count_q;
	logic [SlotW-1:0]                wslot_q;
	logic [TotW-1:0]                 total_q;

	logic [SlotW-1:0]                ptr_q;
	logic [SlotW-1:0]                cmp_slot_q;
	logic                            rvalid_q;
	logic [TotW-1:0]                 before_q;

	logic [SlotW-1:0]                res_slot_q;
	logic [rswps_pkg::OFF_W-1:0]     res_off_q;
	logic                            res_err_q;

	logic                            we;
	logic [SlotW-1:0]                waddr;
	logic [SlotW-1:0]                raddr;
	logic [rswps_pkg::LEN_W-1:0]     rdata;
	logic [TotW-1:0]                 after;
	logic [CmpW-1:0]                 diff;
	logic [rswps_pkg::LEN_W-1:0]     len_clamped;

	assign len_clamped = (in_episode_length > rswps_pkg::LEN_CLAMP) ? rswps_pkg::LEN_CLAMP
		: in_episode_length;

	assign we    = cmd.add_new || cmd.add_replace;
	assign waddr = cmd.add_new ? count_q[SlotW-1:0] : wslot_q;
	assign raddr = cmd.walk_step ? ptr_q : wslot_q;

	rswps_ram #(
		.WIDTH (rswps_pkg::LEN_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (len_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign after = before_q + TotW'(rdata);
	assign diff  = CmpW'(draw_q) - CmpW'(before_q);

	always_comb begin
		sts.is_add   = (op_q == rswps_pkg::OP_ADD);
		sts.full     = (count_q == FullCnt);
		sts.bad_draw = (count_q == '0) || (total_q == '0) || (CmpW'(draw_q) >= CmpW'(total_q));
		sts.found    = rvalid_q && (CmpW'(draw_q) < CmpW'(after));
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= in_op;
			len_q  <= len_clamped;
			draw_q <= in_draw;
			last_q <= in_batch_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wslot_q  <= '0;
			total_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (cmd.add_new) begin
				count_q <= count_q + CntW'(1);
				total_q <= total_q + TotW'(len_q);
			end
			if (cmd.add_replace) begin
				total_q <= total_q - TotW'(rdata) + TotW'(len_q);
				wslot_q <= (wslot_q == LastSlot) ? '0 : wslot_q + SlotW'(1);
			end
			if (cmd.walk_start) begin
				rvalid_q <= 1'b0;
			end else if (cmd.walk_step) begin
				rvalid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			ptr_q    <= '0;
			before_q <= '0;
		end else if (cmd.walk_step) begin
			ptr_q      <= ptr_q + SlotW'(1);
			cmp_slot_q <= ptr_q;
			if (rvalid_q) begin
				before_q <= after;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_new) begin
			res_slot_q <= count_q[SlotW-1:0];
			res_off_q  <= '0;
			res_err_q  <= 1'b0;
		end else if (cmd.add_replace) begin
			res_slot_q <= wslot_q;
			res_off_q  <= '0;
			res_err_q  <= 1'b0;
		end else if (cmd.set_err) begin
			res_slot_q <= '0;
			res_off_q  <= '0;
			res_err_q  <= 1'b1;
		end else if (cmd.walk_step && sts.found) begin
			res_slot_q <= cmp_slot_q;
			res_off_q  <= rswps_pkg::OFF_W'(diff);
			res_err_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			slot_index      <= rswps_pkg::SLOT_W'(res_slot_q);
			offset          <= res_off_q;
			total_positions <= rswps_pkg::TOTAL_W'(total_q);
			stored_count    <= rswps_pkg::COUNT_W'(count_q);
			error           <= res_err_q;
			batch_end       <= (op_q == rswps_pkg::OP_SAMPLE) && last_q;
		end
	end

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for ring_store_weighted_position_sampler: drives add and sample words,
// predicts each response from a local copy of the ring and compares it field by field.
// Depends on rswps_pkg, the rswps_req_if/rswps_rsp_if interfaces and the RTL under hdl.
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [rswps_pkg::SLOT_W-1:0]  slot_index;
		logic [rswps_pkg::OFF_W-1:0]   offset;
		logic [rswps_pkg::TOTAL_W-1:0] total_positions;
		logic [rswps_pkg::COUNT_W-1:0] stored_count;
		logic                          error;
		logic                          batch_end;
	} position_t;

	logic clk;
	logic arst_n;

	rswps_req_if req_ch ();
	rswps_rsp_if rsp_ch ();

	ring_store_weighted_position_sampler i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [rswps_pkg::LEN_W-1:0] ring_len [rswps_pkg::CAPACITY];
	int unsigned                 ring_count;
	int unsigned                 ring_head;
	int unsigned                 ring_sum;

	position_t pending_positions [$];
	int        mismatches;
	bit        idle_on;
	int        sink_hold;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic position_t predict_position(logic op,
		logic [rswps_pkg::LEN_W-1:0] len, logic [rswps_pkg::DRAW_W-1:0] draw, logic last);
		position_t   p;
		int unsigned slot;
		int unsigned clen;
		int unsigned prefix;
		int unsigned s;
		bit          found;
		p = '0;
		if (op == rswps_pkg::OP_ADD) begin
			clen = (len > rswps_pkg::LEN_CLAMP) ? rswps_pkg::LEN_CLAMP : len;
			if (ring_count < rswps_pkg::CAPACITY) begin
				slot = ring_count;
				ring_count++;
			end else begin
				slot = ring_head;
				ring_sum -= ring_len[slot];
				ring_head = (slot + 1) % rswps_pkg::CAPACITY;
			end
			ring_len[slot] = rswps_pkg::LEN_W'(clen);
			ring_sum += clen;
			p.slot_index = rswps_pkg::SLOT_W'(slot);
		end else begin
			p.batch_end = last;
			if (ring_count == 0 || ring_sum == 0 || draw >= ring_sum) begin
				p.error = 1'b1;
			end else begin
				prefix = 0;
				found = 1'b0;
				for (s = 0; s < ring_count && !found; s++) begin
					if (draw < prefix + ring_len[s]) begin
						p.slot_index = rswps_pkg::SLOT_W'(s);
						p.offset = rswps_pkg::OFF_W'(draw - prefix);
						found = 1'b1;
					end else begin
						prefix += ring_len[s];
					end
				end
				if (!found)
					p.error = 1'b1;
			end
		end
		p.total_positions = rswps_pkg::TOTAL_W'(ring_sum);
		p.stored_count = rswps_pkg::COUNT_W'(ring_count);
		return p;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned pick_length();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		else if (r == 1)
			return $urandom_range(rswps_pkg::MAX_LENGTH + 1, (1 << rswps_pkg::LEN_W) - 1);
		else if (r == 2)
			return rswps_pkg::MAX_LENGTH;
		return $urandom_range(1, rswps_pkg::MAX_LENGTH);
	endfunction

	function automatic int unsigned pick_draw();
		int r;
		r = $urandom_range(0, 19);
		if (ring_sum == 0 || r == 2)
			return $urandom_range(0, (1 << rswps_pkg::DRAW_W) - 1);
		else if (r == 0)
			return ring_sum;
		else if (r == 1)
			return ring_sum - 1;
		return $urandom_range(0, ring_sum - 1);
	endfunction

	task automatic send_word(input logic op, input int unsigned len, input int unsigned draw,
		input logic last);
		int gap;
		gap = (idle_on && $urandom_range(0, 1)) ? pick_gap() : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.op             <= op;
		req_ch.episode_length <= rswps_pkg::LEN_W'(len);
		req_ch.draw           <= rswps_pkg::DRAW_W'(draw);
		req_ch.batch_last     <= last;
		do @(posedge clk); while (!req_ch.ready);
		pending_positions.insert(pending_positions.size(),
			predict_position(op, rswps_pkg::LEN_W'(len), rswps_pkg::DRAW_W'(draw), last));
	endtask

	task automatic send_add(input int unsigned len);
		send_word(rswps_pkg::OP_ADD, len, $urandom_range(0, (1 << rswps_pkg::DRAW_W) - 1),
			1'($urandom_range(0, 1)));
	endtask

	task automatic send_sample(input int unsigned draw, input logic last);
		send_word(rswps_pkg::OP_SAMPLE, $urandom_range(0, (1 << rswps_pkg::LEN_W) - 1), draw,
			last);
	endtask

	task automatic send_mixed(input int add_pct);
		if ($urandom_range(0, 99) < add_pct)
			send_add(pick_length());
		else
			send_sample(pick_draw(), $urandom_range(0, 7) == 0);
	endtask

	task automatic test_directed();
		idle_on = 1'b1;
		send_sample(0, 1'b1);
		send_sample((1 << rswps_pkg::DRAW_W) - 1, 1'b0);
		send_add(0);
		send_sample(0, 1'b1);
		send_add((1 << rswps_pkg::LEN_W) - 1);
		send_add(rswps_pkg::MAX_LENGTH);
		send_add(1);
		send_add(0);
		send_sample(0, 1'b0);
		send_sample(rswps_pkg::MAX_LENGTH - 1, 1'b1);
		send_sample(rswps_pkg::MAX_LENGTH, 1'b0);
		send_sample(2 * rswps_pkg::MAX_LENGTH - 1, 1'b0);
		send_sample(2 * rswps_pkg::MAX_LENGTH, 1'b1);
		send_sample(2 * rswps_pkg::MAX_LENGTH + 1, 1'b0);
		send_sample(2 * rswps_pkg::MAX_LENGTH + 2, 1'b0);
		send_sample((1 << rswps_pkg::DRAW_W) - 1, 1'b1);
		send_add(700);
		send_sample(3 * rswps_pkg::MAX_LENGTH, 1'b0);
		send_sample(2 * rswps_pkg::MAX_LENGTH + 1, 1'b1);
	endtask

	task automatic test_fill();
		idle_on = 1'b1;
		while (ring_count < rswps_pkg::CAPACITY)
			send_mixed(70);
	endtask

	task automatic test_overwrite();
		idle_on = 1'b1;
		repeat (400) send_mixed(50);
	endtask

	task automatic test_full_scale();
		idle_on = 1'b1;
		repeat (rswps_pkg::CAPACITY)
			send_add($urandom_range(rswps_pkg::MAX_LENGTH, (1 << rswps_pkg::LEN_W) - 1));
		send_sample((1 << rswps_pkg::DRAW_W) - 1, 1'b1);
		send_sample((1 << rswps_pkg::DRAW_W) - 2, 1'b0);
		send_sample(0, 1'b0);
		send_sample(1 << (rswps_pkg::DRAW_W - 1), 1'b1);
		repeat (76)
			send_sample($urandom_range(0, (1 << rswps_pkg::DRAW_W) - 1),
				1'($urandom_range(0, 1)));
	endtask

	task automatic test_streaming();
		idle_on = 1'b0;
		repeat (200) send_mixed(40);
	endtask

	task automatic test_noise();
		idle_on = 1'b1;
		repeat (80)
			send_word(1'($urandom_range(0, 1)), $urandom_range(0, (1 << rswps_pkg::LEN_W) - 1),
				$urandom_range(0, (1 << rswps_pkg::DRAW_W) - 1), 1'($urandom_range(0, 1)));
	endtask

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			rsp_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			sink_hold = pick_gap();
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic report_field(input string name, input logic [31:0] expv,
		input logic [31:0] actv);
		if (actv !== expv) begin
			mismatches++;
			if (mismatches <= 40)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expv,
					actv);
		end
	endtask

	always @(posedge clk) begin
		position_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_positions.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t ns: unexpected word, expected none, actual slot %0d",
						$time, rsp_ch.slot_index);
			end else begin
				e = pending_positions.pop_front();
				report_field("slot_index", e.slot_index, rsp_ch.slot_index);
				report_field("offset", e.offset, rsp_ch.offset);
				report_field("total_positions", e.total_positions, rsp_ch.total_positions);
				report_field("stored_count", e.stored_count, rsp_ch.stored_count);
				report_field("error", e.error, rsp_ch.error);
				report_field("batch_end", e.batch_end, rsp_ch.batch_end);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n                = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.op             = rswps_pkg::OP_ADD;
		req_ch.episode_length = '0;
		req_ch.draw           = '0;
		req_ch.batch_last     = 1'b0;
		rsp_ch.ready          = 1'b0;
		ring_count            = 0;
		ring_head             = 0;
		ring_sum              = 0;
		mismatches            = 0;
		idle_on               = 1'b0;
		sink_hold             = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill();
		test_overwrite();
		test_full_scale();
		test_streaming();
		test_noise();

		req_ch.valid <= 1'b0;
		idle_on = 1'b0;
		while (pending_positions.size() != 0)
			@(posedge clk);
		repeat (rswps_pkg::CAPACITY + 16) @(posedge clk);
		if (mismatches == 0 && pending_positions.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
